### src/tti_pkg.sv
// Shared types and constants for the transform tween interpolator.
// Used by the channel interfaces, the divider, the lerp datapath and the top level.
// No dependencies.
package tti_pkg;

    localparam int COMP_W      = 16;
    localparam int VEC_W       = 3 * COMP_W;
    localparam int LEN_W       = 32;
    localparam int STEP_W      = 16;
    localparam int T_W         = 17;
    localparam int SUM_W       = LEN_W + 1;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = VEC_W;
    localparam int MODE_W      = 2;
    localparam int PROD_W      = 36;
    localparam int CNT_W       = 6;

    localparam int MODE_LOOP_BIT = 0;
    localparam int MODE_REL_BIT  = 1;

    // shift-subtract step counts: modulo of the 33-bit sum, then the 17 bits of t
    localparam logic [CNT_W-1:0] DIV_MOD_LAST = CNT_W'(SUM_W - 1);
    localparam logic [CNT_W-1:0] DIV_T_LAST   = CNT_W'(T_W - 1);

    localparam logic [VEC_W-1:0]  SCALE_ONE_RESET = 48'h0100_0100_0100;
    localparam logic [LEN_W-1:0]  LEN_RESET       = 32'd1000;
    localparam logic [MODE_W-1:0] MODE_RESET      = 2'b00;
    localparam logic [1:0]        LANE_LAST       = 2'd2;

    typedef enum logic {
        FUNC_ADVANCE = 1'b0,
        FUNC_RESTART = 1'b1
    } func_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_START_POS   = 4'd0,
        REG_START_ROT   = 4'd1,
        REG_START_SCALE = 4'd2,
        REG_END_POS     = 4'd3,
        REG_END_ROT     = 4'd4,
        REG_END_SCALE   = 4'd5,
        REG_ANIM_LEN    = 4'd6,
        REG_CTRL_MODE   = 4'd7
    } cfg_index_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_TLOAD,
        S_DIV,
        S_LERP,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        GRP_POS   = 2'd0,
        GRP_ROT   = 2'd1,
        GRP_SCALE = 2'd2
    } group_t;

    typedef enum logic [1:0] {
        PH_PRE = 2'd0,   // relative scale product
        PH_END = 2'd1,   // end value and delta
        PH_MUL = 2'd2,   // delta times t
        PH_ACC = 2'd3    // round and add start
    } phase_t;

    typedef struct packed {
        logic              load;
        logic              step;
        logic              shift;
        logic [LEN_W-1:0]  init_rem;
        logic [SUM_W-1:0]  init_din;
    } div_ctrl_t;

    typedef struct packed {
        logic       active;
        phase_t     phase;
        group_t     grp;
        logic [1:0] lane;
    } lerp_ctrl_t;

    typedef logic [2:0][2:0][COMP_W-1:0] res_grid_t;

endpackage

### src/tti_item_if.sv
// Input item channel: valid/ready handshake with func and step_time.
// Depends on tti_pkg.
interface tti_item_if import tti_pkg::*;;
    logic              valid;
    logic              ready;
    logic              func;
    logic [STEP_W-1:0] step_time;

    modport source (output valid, output func, output step_time, input ready);
    modport sink   (input valid, input func, input step_time, output ready);
endinterface

### src/tti_result_if.sv
// Result channel: valid/ready handshake with the nine Q8.8 components and finished.
// Depends on tti_pkg.
interface tti_result_if import tti_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [COMP_W-1:0] pos_x;
    logic signed [COMP_W-1:0] pos_y;
    logic signed [COMP_W-1:0] pos_z;
    logic signed [COMP_W-1:0] rot_x;
    logic signed [COMP_W-1:0] rot_y;
    logic signed [COMP_W-1:0] rot_z;
    logic signed [COMP_W-1:0] scale_x;
    logic signed [COMP_W-1:0] scale_y;
    logic signed [COMP_W-1:0] scale_z;
    logic                     finished;

    modport source (output valid, output pos_x, output pos_y, output pos_z,
                    output rot_x, output rot_y, output rot_z,
                    output scale_x, output scale_y, output scale_z,
                    output finished, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                    input rot_x, input rot_y, input rot_z,
                    input scale_x, input scale_y, input scale_z,
                    input finished, output ready);
endinterface

### src/tti_cfg_if.sv
// Configuration write channel: valid/ready handshake with register index and data.
// Depends on tti_pkg.
interface tti_cfg_if import tti_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### src/tti_divider.sv
// Shift-subtract divider step unit, one remainder/quotient bit per cycle while step is set.
// Serves both the elapsed modulo and the t = elapsed*65536/length division.
// Depends on tti_pkg.
module tti_divider
    import tti_pkg::*;
(
    input  logic             clk,
    input  div_ctrl_t        ctrl,
    input  logic [LEN_W-1:0] divisor,
    output logic [LEN_W-1:0] rem,
    output logic [T_W-1:0]   quo
);

    logic [LEN_W-1:0] rem_reg;
    logic [SUM_W-1:0] din_reg;
    logic [T_W-1:0]   quo_reg;
    logic [SUM_W-1:0] trial;
    logic [SUM_W-1:0] diff;
    logic             ge;

    // without shift the first step only compares the loaded remainder
    assign trial = ctrl.shift ? {rem_reg, din_reg[SUM_W-1]} : {1'b0, rem_reg};
    assign diff  = trial - {1'b0, divisor};
    assign ge    = (trial >= {1'b0, divisor});

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            rem_reg <= ctrl.init_rem;
            din_reg <= ctrl.init_din;
            quo_reg <= '0;
        end
        else if (ctrl.step)
        begin
            rem_reg <= ge ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
            din_reg <= {din_reg[SUM_W-2:0], 1'b0};
            quo_reg <= {quo_reg[T_W-2:0], ge};
        end
    end

    assign rem = rem_reg;
    assign quo = quo_reg;

endmodule

### src/tti_lerp.sv
// Lerp datapath around one shared 18x18 signed multiplier, one component per
// four phases: relative scale product, end value and delta, delta*t, round and add.
// Depends on tti_pkg.
module tti_lerp
    import tti_pkg::*;
(
    input  logic                     clk,
    input  lerp_ctrl_t               ctrl,
    input  logic                     rel,
    input  logic signed [COMP_W-1:0] start_val,
    input  logic signed [COMP_W-1:0] end_val,
    input  logic [T_W-1:0]           t,
    output res_grid_t                res
);

    localparam int MUL_W = PROD_W / 2;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [COMP_W:0]   d_reg;
    res_grid_t                res_reg;

    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [COMP_W:0]   add_sum;
    logic signed [PROD_W-1:0] scale_rnd;
    logic signed [PROD_W-1:0] scale_sh;
    logic signed [COMP_W-1:0] end_eff;
    logic signed [PROD_W-1:0] lerp_rnd;
    logic signed [PROD_W-1:0] lerp_sh;

    always_comb
    begin
        if (ctrl.phase == PH_MUL)
        begin
            mul_a = MUL_W'(d_reg);
            mul_b = $signed({1'b0, t});
        end
        else
        begin
            mul_a = MUL_W'(start_val);
            mul_b = MUL_W'(end_val);
        end
    end

    // end value: raw, start + delta, or start * factor in Q8.8, saturated
    always_comb
    begin
        add_sum   = (COMP_W + 1)'(start_val) + (COMP_W + 1)'(end_val);
        scale_rnd = prod_reg + PROD_W'(128);
        scale_sh  = scale_rnd >>> 8;
        if (!rel)
        begin
            end_eff = end_val;
        end
        else if (ctrl.grp == GRP_SCALE)
        begin
            if (scale_sh > PROD_W'(32767))
                end_eff = 16'sh7fff;
            else if (scale_sh < -PROD_W'(32768))
                end_eff = -16'sh8000;
            else
                end_eff = scale_sh[COMP_W-1:0];
        end
        else
        begin
            if (add_sum > 17'sd32767)
                end_eff = 16'sh7fff;
            else if (add_sum < -17'sd32768)
                end_eff = -16'sh8000;
            else
                end_eff = add_sum[COMP_W-1:0];
        end
    end

    assign lerp_rnd = prod_reg + PROD_W'(32768);
    assign lerp_sh  = lerp_rnd >>> 16;

    always_ff @(posedge clk)
    begin
        if (ctrl.active)
        begin
            case (ctrl.phase)
                PH_PRE, PH_MUL:
                begin
                    prod_reg <= mul_a * mul_b;
                end
                PH_END:
                begin
                    d_reg <= (COMP_W + 1)'(end_eff) - (COMP_W + 1)'(start_val);
                end
                default:
                begin
                    // the true result lies between start and end, so 16 bits hold it
                    res_reg[ctrl.grp][ctrl.lane] <= start_val + lerp_sh[COMP_W-1:0];
                end
            endcase
        end
    end

    assign res = res_reg;

endmodule

### src/transform_tween_interpolator_unit.sv
// Transform tween interpolator, top level: registers, elapsed time, sequencer.
// Instantiates tti_divider and tti_lerp; uses tti_pkg and the channel interfaces.
//
// Usage:
//   cfg    - register writes (index, data), always ready; write only while idle.
//   item   - func 0 advances elapsed by step_time, func 1 restarts it at zero.
//            item.ready is high only while the sequencer is idle.
//   result - nine lerped Q8.8 components and finished, one per item.
// Sequence per item, from the transfer on item to result.valid:
//   loop-mode advance: modulo steps, a divider load, the divide steps for t, the
//   lerp phases and the output load; restart or non-loop advance skips the modulo.
//   The single shift-subtract divider (one bit a cycle) and the single
//   multiplier (four phases per component, nine components) set how long an item takes.
//   A new item is taken only once the last one has gone to the output register.
// A finished result sits in the output register; the next item is accepted
// meanwhile, and only its own hand-off waits while result.ready is low.
// Reset: registers take their default values (length 1000, unit scales),
// elapsed is zero, no result is pending.
module transform_tween_interpolator_unit
    import tti_pkg::*;
(
    input logic          clk,
    input logic          rst_n,
    tti_item_if.sink     item,
    tti_result_if.source result,
    tti_cfg_if.sink      cfg
);

    state_t state_reg, state_next;

    logic [VEC_W-1:0]  start_pos_reg, start_rot_reg, start_scale_reg;
    logic [VEC_W-1:0]  end_pos_reg, end_rot_reg, end_scale_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [MODE_W-1:0] mode_reg;
    logic [LEN_W-1:0]  elapsed_reg;
    logic              mod_reg;
    logic [CNT_W-1:0]  cnt_reg;
    phase_t            phase_reg;
    group_t            grp_reg;
    logic [1:0]        lane_reg;

    logic              out_valid_reg;
    res_grid_t         out_res_reg;
    logic              out_fin_reg;

    logic              loop_en, rel_en;
    logic              accept, load_out, lerp_last;
    logic [LEN_W-1:0]  len_eff;
    logic [SUM_W-1:0]  sum;
    logic [LEN_W-1:0]  elapsed_eff;
    logic [LEN_W-1:0]  div_rem;
    logic [T_W-1:0]    t_val;
    div_ctrl_t         div_ctrl;
    lerp_ctrl_t        lerp_ctrl;
    res_grid_t         res;
    logic [VEC_W-1:0]  start_vec, end_vec;
    logic [COMP_W-1:0] start_val, end_val;

    assign loop_en   = mode_reg[MODE_LOOP_BIT];
    assign rel_en    = mode_reg[MODE_REL_BIT];
    assign len_eff   = (len_reg == '0) ? LEN_W'(1) : len_reg;
    assign sum       = {1'b0, elapsed_reg} + SUM_W'(item.step_time);
    assign accept    = item.valid && item.ready;
    assign lerp_last = (phase_reg == PH_ACC) && (grp_reg == GRP_SCALE)
                       && (lane_reg == LANE_LAST);
    assign elapsed_eff = mod_reg ? div_rem : elapsed_reg;

    // configuration writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_pos_reg   <= '0;
            start_rot_reg   <= '0;
            start_scale_reg <= SCALE_ONE_RESET;
            end_pos_reg     <= '0;
            end_rot_reg     <= '0;
            end_scale_reg   <= SCALE_ONE_RESET;
            len_reg         <= LEN_RESET;
            mode_reg        <= MODE_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_START_POS:   start_pos_reg   <= cfg.data;
                REG_START_ROT:   start_rot_reg   <= cfg.data;
                REG_START_SCALE: start_scale_reg <= cfg.data;
                REG_END_POS:     end_pos_reg     <= cfg.data;
                REG_END_ROT:     end_rot_reg     <= cfg.data;
                REG_END_SCALE:   end_scale_reg   <= cfg.data;
                REG_ANIM_LEN:    len_reg         <= cfg.data[LEN_W-1:0];
                REG_CTRL_MODE:   mode_reg        <= cfg.data[MODE_W-1:0];
                default:         ;
            endcase
        end
    end

    // sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item.valid)
                begin
                    if (item.func == FUNC_ADVANCE && loop_en)
                        state_next = S_MOD;
                    else
                        state_next = S_TLOAD;
                end
            end
            S_MOD:
            begin
                if (cnt_reg == '0)
                    state_next = S_TLOAD;
            end
            S_TLOAD:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (cnt_reg == '0)
                    state_next = S_LERP;
            end
            S_LERP:
            begin
                if (lerp_last)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || result.ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // sequencer: outputs
    always_comb
    begin
        item.ready        = 1'b0;
        load_out          = 1'b0;
        div_ctrl          = '0;
        lerp_ctrl.active  = 1'b0;
        lerp_ctrl.phase   = phase_reg;
        lerp_ctrl.grp     = grp_reg;
        lerp_ctrl.lane    = lane_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                item.ready        = 1'b1;
                div_ctrl.load     = item.valid;
                div_ctrl.init_din = sum;
            end
            S_MOD:
            begin
                div_ctrl.step  = 1'b1;
                div_ctrl.shift = 1'b1;
            end
            S_TLOAD:
            begin
                div_ctrl.load     = 1'b1;
                div_ctrl.init_rem = elapsed_eff;
            end
            S_DIV:
            begin
                div_ctrl.step  = 1'b1;
                div_ctrl.shift = (cnt_reg != DIV_T_LAST);
            end
            S_LERP:
            begin
                lerp_ctrl.active = 1'b1;
            end
            S_DONE:
            begin
                load_out = !out_valid_reg || result.ready;
            end
            default:
            begin
                item.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            elapsed_reg <= '0;
            mod_reg     <= 1'b0;
            cnt_reg     <= '0;
            phase_reg   <= PH_PRE;
            grp_reg     <= GRP_POS;
            lane_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        cnt_reg <= DIV_MOD_LAST;
                        mod_reg <= (item.func == FUNC_ADVANCE) && loop_en;
                        if (item.func == FUNC_RESTART)
                            elapsed_reg <= '0;
                        else if (!loop_en)
                            elapsed_reg <= (sum > {1'b0, len_eff}) ? len_eff
                                                                    : sum[LEN_W-1:0];
                    end
                end
                S_MOD:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
                S_TLOAD:
                begin
                    elapsed_reg <= elapsed_eff;
                    cnt_reg     <= DIV_T_LAST;
                    phase_reg   <= PH_PRE;
                    grp_reg     <= GRP_POS;
                    lane_reg    <= '0;
                end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
                S_LERP:
                begin
                    case (phase_reg)
                        PH_PRE: phase_reg <= PH_END;
                        PH_END: phase_reg <= PH_MUL;
                        PH_MUL: phase_reg <= PH_ACC;
                        default:
                        begin
                            phase_reg <= PH_PRE;
                            if (lane_reg == LANE_LAST)
                            begin
                                lane_reg <= '0;
                                case (grp_reg)
                                    GRP_POS: grp_reg <= GRP_ROT;
                                    default: grp_reg <= GRP_SCALE;
                                endcase
                            end
                            else
                            begin
                                lane_reg <= lane_reg + 1'b1;
                            end
                        end
                    endcase
                end
                default:
                begin
                    mod_reg <= mod_reg;
                end
            endcase
        end
    end

    // component select for the lerp datapath
    always_comb
    begin
        case (grp_reg)
            GRP_POS:
            begin
                start_vec = start_pos_reg;
                end_vec   = end_pos_reg;
            end
            GRP_ROT:
            begin
                start_vec = start_rot_reg;
                end_vec   = end_rot_reg;
            end
            default:
            begin
                start_vec = start_scale_reg;
                end_vec   = end_scale_reg;
            end
        endcase
        start_val = start_vec[{lane_reg, 4'b0000} +: COMP_W];
        end_val   = end_vec[{lane_reg, 4'b0000} +: COMP_W];
    end

    tti_divider u_div (
        .clk     (clk),
        .ctrl    (div_ctrl),
        .divisor (len_eff),
        .rem     (div_rem),
        .quo     (t_val)
    );

    tti_lerp u_lerp (
        .clk       (clk),
        .ctrl      (lerp_ctrl),
        .rel       (rel_en),
        .start_val ($signed(start_val)),
        .end_val   ($signed(end_val)),
        .t         (t_val),
        .res       (res)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_res_reg <= res;
            out_fin_reg <= !loop_en && t_val[T_W-1];  // t reached 1.0
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.pos_x    = out_res_reg[GRP_POS][0];
    assign result.pos_y    = out_res_reg[GRP_POS][1];
    assign result.pos_z    = out_res_reg[GRP_POS][2];
    assign result.rot_x    = out_res_reg[GRP_ROT][0];
    assign result.rot_y    = out_res_reg[GRP_ROT][1];
    assign result.rot_z    = out_res_reg[GRP_ROT][2];
    assign result.scale_x  = out_res_reg[GRP_SCALE][0];
    assign result.scale_y  = out_res_reg[GRP_SCALE][1];
    assign result.scale_z  = out_res_reg[GRP_SCALE][2];
    assign result.finished = out_fin_reg;

endmodule

### src/tti_checker.sv
// Port-level checks for the tween interpolator, bound to the top level.
// Depends on transform_tween_interpolator_unit and its channel interfaces.
module tti_checker
    import tti_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_ready,
    input logic              result_valid,
    input logic              result_ready,
    input logic [COMP_W-1:0] result_pos_x,
    input logic              result_finished
);

    // one item at a time: no transfer right after another
    a_busy_after_item: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("item channel ready right after an item transfer");

    // a result is parked in the output register and the block is idle again
    a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> item_ready)
        else $error("result presented while the block is still busy");

    // a new result never shows up the cycle after an item transfer
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && !result_valid |=> !result_valid)
        else $error("result appeared one cycle after an item transfer");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_pos_x)
                                          && $stable(result_finished))
        else $error("stalled result dropped or changed");

endmodule

bind transform_tween_interpolator_unit tti_checker u_tti_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_valid      (item.valid),
    .item_ready      (item.ready),
    .result_valid    (result.valid),
    .result_ready    (result.ready),
    .result_pos_x    (result.pos_x),
    .result_finished (result.finished)
);
